/* sv/itc_pkg.sv */
// ----------------------------------------------------------------------------
// itc_pkg
// Shared codes and types for the interval timer channel in rate mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

  // item kinds on the input channel
  localparam logic [1:0] ItemTick  = 2'd0;
  localparam logic [1:0] ItemWrite = 2'd1;
  localparam logic [1:0] ItemRead  = 2'd2;

  // bus port offsets
  localparam logic [1:0] PortChan0 = 2'd0;
  localparam logic [1:0] PortCmd   = 2'd3;

  // channel select field of a command byte
  localparam logic [1:0] SelChan0 = 2'd0;

  // access field of a command byte
  localparam logic [1:0] AccLatch = 2'd0;
  localparam logic [1:0] AccLow   = 2'd1;
  localparam logic [1:0] AccHigh  = 2'd2;
  localparam logic [1:0] AccBoth  = 2'd3;

  // one result of a transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } result_t;

endpackage

`default_nettype wire

/* sv/itc_core.sv */
// ----------------------------------------------------------------------------
// itc_core
// Counter, divisor, latch and byte flip-flops; one transaction per cycle with accept_i.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itc_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [1:0]      mode_i,
  input  wire logic [1:0]      port_i,
  input  wire logic [7:0]      write_data_i,
  output itc_pkg::result_t     result_o
);

  logic [15:0] count_q,   count_d;
  logic [15:0] reload_q,  reload_d;
  logic [15:0] latched_q, latched_d;
  logic        latch_held_q, latch_held_d;
  logic        rd_high_q,    rd_high_d;
  logic        wr_high_q,    wr_high_d;
  logic [1:0]  access_q,     access_d;
  logic        counting_q,   counting_d;

  logic [1:0]  cmd_sel;
  logic [1:0]  cmd_acc;
  logic [15:0] rd_src;

  assign cmd_sel = write_data_i[7:6];
  assign cmd_acc = write_data_i[5:4];
  assign rd_src  = latch_held_q ? latched_q : count_q;

  // next state and result of one transaction
  always_comb begin
    count_d      = count_q;
    reload_d     = reload_q;
    latched_d    = latched_q;
    latch_held_d = latch_held_q;
    rd_high_d    = rd_high_q;
    wr_high_d    = wr_high_q;
    access_d     = access_q;
    counting_d   = counting_q;
    result_o     = '0;

    unique case (mode_i)
      itc_pkg::ItemTick: begin
        if (counting_q) begin
          if (count_q == 16'd1) begin
            result_o.irq = 1'b1;
            count_d      = reload_q;
          end else begin
            count_d = count_q - 16'd1;
          end
        end
      end

      itc_pkg::ItemWrite: begin
        if (port_i == itc_pkg::PortCmd) begin
          if (cmd_sel == itc_pkg::SelChan0) begin
            if (cmd_acc == itc_pkg::AccLatch) begin
              // latch the live count unless a latched value is pending
              if (!latch_held_q) begin
                latched_d    = count_q;
                latch_held_d = 1'b1;
              end
            end else begin
              access_d     = cmd_acc;
              rd_high_d    = 1'b0;
              wr_high_d    = 1'b0;
              latch_held_d = 1'b0;
              counting_d   = 1'b0;
            end
          end
        end else if (port_i == itc_pkg::PortChan0) begin
          // divisor load, restart once complete
          priority if (access_q == itc_pkg::AccLow) begin
            reload_d   = {8'd0, write_data_i};
            count_d    = {8'd0, write_data_i};
            counting_d = 1'b1;
          end else if (access_q == itc_pkg::AccHigh) begin
            reload_d   = {write_data_i, 8'd0};
            count_d    = {write_data_i, 8'd0};
            counting_d = 1'b1;
          end else if (!wr_high_q) begin
            reload_d  = {reload_q[15:8], write_data_i};
            wr_high_d = 1'b1;
          end else begin
            reload_d   = {write_data_i, reload_q[7:0]};
            count_d    = {write_data_i, reload_q[7:0]};
            wr_high_d  = 1'b0;
            counting_d = 1'b1;
          end
        end
      end

      itc_pkg::ItemRead: begin
        if (port_i == itc_pkg::PortChan0) begin
          priority if (access_q == itc_pkg::AccLow) begin
            result_o.read_data = rd_src[7:0];
            latch_held_d       = 1'b0;
          end else if (access_q == itc_pkg::AccHigh) begin
            result_o.read_data = rd_src[15:8];
            latch_held_d       = 1'b0;
          end else if (!rd_high_q) begin
            result_o.read_data = rd_src[7:0];
            rd_high_d          = 1'b1;
          end else begin
            result_o.read_data = rd_src[15:8];
            rd_high_d          = 1'b0;
            latch_held_d       = 1'b0;
          end
        end
      end

      default: begin
        // unused item kind: no change
      end
    endcase
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      reload_q     <= '0;
      latched_q    <= '0;
      latch_held_q <= 1'b0;
      rd_high_q    <= 1'b0;
      wr_high_q    <= 1'b0;
      access_q     <= itc_pkg::AccBoth;
      counting_q   <= 1'b0;
    end else if (accept_i) begin
      count_q      <= count_d;
      reload_q     <= reload_d;
      latched_q    <= latched_d;
      latch_held_q <= latch_held_d;
      rd_high_q    <= rd_high_d;
      wr_high_q    <= wr_high_d;
      access_q     <= access_d;
      counting_q   <= counting_d;
    end
  end

endmodule

`default_nettype wire

/* sv/interval_timer_channel_rate_mode.sv */
// ----------------------------------------------------------------------------
// interval_timer_channel_rate_mode
// Channel 0 of an interval timer as a rate generator, with a registered,
// skid-buffered result channel.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid_i/in_ready_o | mode_i, port_i, write_data_i
//  out     | out_valid_o/out_ready_i | read_data_o, irq_o
//
//  one transaction per cycle while in_ready_o is high; each result is registered in out_q or skid_q
//  state updates in the accepting cycle, so the next item sees it at once
//  a skid register holds one result while the output is stalled; in_ready_o
//  drops only while that skid register is full
//  reset clears the counter, divisor and latch, access both bytes, stopped
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_channel_rate_mode (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] mode_i,
  input  wire logic [1:0] port_i,
  input  wire logic [7:0] write_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      read_data_o,
  output logic            irq_o
);

  itc_pkg::result_t res;
  itc_pkg::result_t out_q;
  itc_pkg::result_t skid_q;
  logic             out_valid_q;
  logic             skid_valid_q;
  logic             accept;
  logic             out_free;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // channel state and per-transaction logic
  itc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .mode_i       (mode_i),
    .port_i       (port_i),
    .write_data_i (write_data_i),
    .result_o     (res)
  );

  // output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_q.read_data;
  assign irq_o       = out_q.irq;

endmodule

`default_nettype wire
